@@ src/wrp_pkg.sv @@
// Package for the WAV RIFF header parser: shared types, codes and constants.
// No dependencies; every other file imports it.
`default_nettype none
package wrp_pkg;

    localparam int POS_W = 32;  // byte position counter width (16..32)
    localparam int BPF_W = 18;  // bytes per frame: 16-bit channels times up to 4

    localparam logic [31:0] TAG_FMT      = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA     = 32'h6174_6164;
    localparam logic [15:0] FMT_EXT      = 16'hFFFE;
    localparam logic [15:0] FMT_PCM      = 16'd1;
    localparam logic [15:0] FMT_FLOAT    = 16'd3;
    localparam logic [31:0] SUB_PCM      = 32'h0000_0001;
    localparam logic [31:0] SUB_FLOAT    = 32'h0000_0003;
    localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
    localparam logic [31:0] EXT_MIN_LEN  = 32'd40;
    localparam logic [15:0] EXT_MIN_SIZE = 16'd22;
    localparam logic [15:0] BITS_PCM     = 16'd16;
    localparam logic [15:0] BITS_FLOAT   = 16'd32;

    typedef enum logic [1:0] {
        PH_RIFF = 2'd0,
        PH_HDR  = 2'd1,
        PH_BODY = 2'd2,
        PH_PAD  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_CHECK = 2'd1,
        ST_DIV   = 2'd2,
        ST_OUT   = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } in_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic        sample_format;
        logic [31:0] frame_count;
        logic [31:0] data_offset;
        logic [31:0] data_size;
    } out_t;

    typedef struct packed {
        logic take;   // input byte transfer
        logic check;  // evaluate final checks, start divide
        logic load;   // capture result
        logic clear;  // result transfer, back to reset state
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } sts_t;

    // RIFF/WAVE magic by header position; 0 for the size bytes
    function automatic logic [7:0] magic_byte(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = 8'h52;
            4'd1:    r = 8'h49;
            4'd2:    r = 8'h46;
            4'd3:    r = 8'h46;
            4'd8:    r = 8'h57;
            4'd9:    r = 8'h41;
            4'd10:   r = 8'h56;
            4'd11:   r = 8'h45;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ src/wrp_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on wrp_pkg.
`default_nettype none
module wrp_div
    import wrp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [31:0]      dividend,
    input  wire logic [BPF_W-1:0] divisor,
    output logic [31:0]           quotient,
    output logic [BPF_W-1:0]      remainder,
    output logic                  done
);
    logic [31:0]      quo_reg, quo_next;
    logic [BPF_W-1:0] rem_reg, rem_next;
    logic [BPF_W-1:0] dsr_reg, dsr_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [BPF_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[31]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? BPF_W'(trial - {1'b0, dsr_reg}) : trial[BPF_W-1:0];
            quo_next = {quo_reg[30:0], fits};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
endmodule
`default_nettype wire

@@ src/wrp_dp.sv @@
// Datapath: byte parser state, fmt/data capture, final checks, divider, result register.
// Depends on wrp_pkg and wrp_div.
`default_nettype none
module wrp_dp
    import wrp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire in_t  s_data,
    input  wire cmd_t cmd,
    output sts_t      sts,
    output out_t      m_data
);
    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [2:0]       hcnt_reg, hcnt_next;
    logic [31:0]      tag_reg, tag_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      remn_reg, remn_next;
    logic [4:0]       bidx_reg, bidx_next;
    logic             pad_reg, pad_next;
    logic             infmt_reg, infmt_next;
    logic [15:0]      af_reg, af_next;
    logic [15:0]      ch_reg, ch_next;
    logic [31:0]      rate_reg, rate_next;
    logic [15:0]      balign_reg, balign_next;
    logic [15:0]      bits_reg, bits_next;
    logic [15:0]      ext_reg, ext_next;
    logic [31:0]      sub_reg, sub_next;
    logic             fseen_reg, fseen_next;
    logic             dseen_reg, dseen_next;
    logic [31:0]      dstart_reg, dstart_next;
    logic [31:0]      dlen_reg, dlen_next;
    logic             fail_reg, fail_next;

    logic             okpre_reg;
    logic             fcode_reg;
    logic [BPF_W-1:0] bpf_reg;
    out_t             res_reg;

    logic [7:0]       b;
    logic             end_now;
    logic [31:0]      new_len;
    logic             is_pcm, is_flt;
    logic [BPF_W-1:0] bpf;
    logic             ok_pre;
    logic [31:0]      quo;
    logic [BPF_W-1:0] rmd;
    logic             div_done;

    assign b       = s_data.in_byte;
    assign new_len = {b, len_reg[31:8]};

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        hcnt_next   = hcnt_reg;
        tag_next    = tag_reg;
        len_next    = len_reg;
        remn_next   = remn_reg;
        bidx_next   = bidx_reg;
        pad_next    = pad_reg;
        infmt_next  = infmt_reg;
        af_next     = af_reg;
        ch_next     = ch_reg;
        rate_next   = rate_reg;
        balign_next = balign_reg;
        bits_next   = bits_reg;
        ext_next    = ext_reg;
        sub_next    = sub_reg;
        fseen_next  = fseen_reg;
        dseen_next  = dseen_reg;
        dstart_next = dstart_reg;
        dlen_next   = dlen_reg;
        fail_next   = fail_reg;
        end_now     = 1'b0;

        if (cmd.clear) begin
            phase_next  = PH_RIFF;
            pos_next    = '0;
            hcnt_next   = '0;
            tag_next    = '0;
            len_next    = '0;
            remn_next   = '0;
            bidx_next   = '0;
            pad_next    = 1'b0;
            infmt_next  = 1'b0;
            af_next     = '0;
            ch_next     = '0;
            rate_next   = '0;
            balign_next = '0;
            bits_next   = '0;
            ext_next    = '0;
            sub_next    = '0;
            fseen_next  = 1'b0;
            dseen_next  = 1'b0;
            dstart_next = '0;
            dlen_next   = '0;
            fail_next   = 1'b0;
        end else if (cmd.take) begin
            case (phase_reg)
                PH_RIFF: begin
                    if ((pos_reg < POS_W'(4) || pos_reg >= POS_W'(8))
                        && b != magic_byte(pos_reg[3:0])) begin
                        fail_next = 1'b1;
                    end
                    if (pos_reg >= POS_W'(11)) begin
                        phase_next = PH_HDR;
                        hcnt_next  = '0;
                    end
                end
                PH_HDR: begin
                    if (hcnt_reg < 3'd4) tag_next = {b, tag_reg[31:8]};
                    else                 len_next = new_len;
                    hcnt_next = hcnt_reg + 3'd1;
                    if (hcnt_reg == 3'd7) begin
                        remn_next  = new_len;
                        bidx_next  = '0;
                        pad_next   = new_len[0];
                        infmt_next = 1'b0;
                        if (tag_reg == TAG_FMT) begin
                            if (new_len < FMT_MIN_LEN) fail_next = 1'b1;
                            infmt_next = 1'b1;
                        end else if (tag_reg == TAG_DATA) begin
                            dseen_next  = 1'b1;
                            dstart_next = 32'(pos_reg) + 32'd1;
                            dlen_next   = new_len;
                        end
                        if (new_len == '0) end_now = 1'b1;
                        else               phase_next = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (infmt_reg) begin
                        if (bidx_reg < 5'd2)
                            af_next[{bidx_reg[0], 3'b000} +: 8] = b;
                        else if (bidx_reg < 5'd4)
                            ch_next[{bidx_reg[0], 3'b000} +: 8] = b;
                        else if (bidx_reg < 5'd8)
                            rate_next[{bidx_reg[1:0], 3'b000} +: 8] = b;
                        else if (bidx_reg == 5'd12 || bidx_reg == 5'd13)
                            balign_next[{bidx_reg[0], 3'b000} +: 8] = b;
                        else if (bidx_reg == 5'd14 || bidx_reg == 5'd15)
                            bits_next[{bidx_reg[0], 3'b000} +: 8] = b;
                        else if (bidx_reg == 5'd16 || bidx_reg == 5'd17)
                            ext_next[{bidx_reg[0], 3'b000} +: 8] = b;
                        else if (bidx_reg >= 5'd24 && bidx_reg < 5'd28)
                            sub_next[{bidx_reg[1:0], 3'b000} +: 8] = b;
                    end
                    if (bidx_reg != 5'd31) bidx_next = bidx_reg + 5'd1;
                    remn_next = remn_reg - 32'd1;
                    if (remn_reg == 32'd1) end_now = 1'b1;
                end
                PH_PAD: begin
                    phase_next = PH_HDR;
                    hcnt_next  = '0;
                end
                default: begin
                    phase_next = PH_HDR;
                end
            endcase

            // end of a chunk body; fmt fixups see this byte's captures
            if (end_now) begin
                if (infmt_next) begin
                    if (af_next == FMT_EXT) begin
                        if (len_next < EXT_MIN_LEN || ext_next < EXT_MIN_SIZE)
                            fail_next = 1'b1;
                        else if (sub_next == SUB_PCM)   af_next = FMT_PCM;
                        else if (sub_next == SUB_FLOAT) af_next = FMT_FLOAT;
                        else fail_next = 1'b1;
                    end
                    fseen_next = 1'b1;
                    infmt_next = 1'b0;
                end
                phase_next = pad_next ? PH_PAD : PH_HDR;
                hcnt_next  = '0;
            end

            if (pos_reg == '1) fail_next = 1'b1;
            else               pos_next  = pos_reg + POS_W'(1);
        end
    end

    // final checks, taken after the last byte has updated the state
    assign is_pcm = af_reg == FMT_PCM && bits_reg == BITS_PCM;
    assign is_flt = af_reg == FMT_FLOAT && bits_reg == BITS_FLOAT;
    assign bpf    = is_pcm ? {1'b0, ch_reg, 1'b0} :
                    is_flt ? {ch_reg, 2'b00} : '0;
    assign ok_pre = !fail_reg && phase_reg != PH_RIFF && phase_reg != PH_BODY
                    && fseen_reg && dseen_reg && ch_reg != '0 && rate_reg != '0
                    && (is_pcm || is_flt) && {2'b00, balign_reg} == bpf
                    && bpf != '0 && dlen_reg != '0;

    wrp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.check),
        .dividend  (dlen_reg),
        .divisor   (bpf),
        .quotient  (quo),
        .remainder (rmd),
        .done      (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_RIFF;
            pos_reg    <= '0;
            hcnt_reg   <= '0;
            tag_reg    <= '0;
            len_reg    <= '0;
            remn_reg   <= '0;
            bidx_reg   <= '0;
            pad_reg    <= 1'b0;
            infmt_reg  <= 1'b0;
            af_reg     <= '0;
            ch_reg     <= '0;
            rate_reg   <= '0;
            balign_reg <= '0;
            bits_reg   <= '0;
            ext_reg    <= '0;
            sub_reg    <= '0;
            fseen_reg  <= 1'b0;
            dseen_reg  <= 1'b0;
            dstart_reg <= '0;
            dlen_reg   <= '0;
            fail_reg   <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            hcnt_reg   <= hcnt_next;
            tag_reg    <= tag_next;
            len_reg    <= len_next;
            remn_reg   <= remn_next;
            bidx_reg   <= bidx_next;
            pad_reg    <= pad_next;
            infmt_reg  <= infmt_next;
            af_reg     <= af_next;
            ch_reg     <= ch_next;
            rate_reg   <= rate_next;
            balign_reg <= balign_next;
            bits_reg   <= bits_next;
            ext_reg    <= ext_next;
            sub_reg    <= sub_next;
            fseen_reg  <= fseen_next;
            dseen_reg  <= dseen_next;
            dstart_reg <= dstart_next;
            dlen_reg   <= dlen_next;
            fail_reg   <= fail_next;
        end

        if (cmd.check) begin
            okpre_reg <= ok_pre;
            fcode_reg <= is_flt;
            bpf_reg   <= bpf;
        end

        if (cmd.load) begin
            if (okpre_reg && rmd == '0) begin
                res_reg.ok            <= 1'b1;
                res_reg.channels      <= ch_reg;
                res_reg.sample_rate   <= rate_reg;
                res_reg.sample_format <= fcode_reg;
                res_reg.frame_count   <= quo;
                res_reg.data_offset   <= dstart_reg;
                res_reg.data_size     <= dlen_reg;
            end else begin
                res_reg <= '0;
            end
        end
    end

    assign sts.div_done = div_done;
    assign m_data       = res_reg;

    a_ok_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load && okpre_reg |-> bpf_reg != '0)
        else $error("accepted result with zero frame size");
endmodule
`default_nettype wire

@@ src/wrp_ctrl.sv @@
// Controller: sequences byte intake, final check, divide and result handoff.
// Depends on wrp_pkg.
`default_nettype none
module wrp_ctrl
    import wrp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    input  wire logic s_last,
    input  wire logic m_ready,
    input  wire sts_t sts,
    output logic      s_ready,
    output logic      m_valid,
    output cmd_t      cmd
);
    ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:   if (s_valid && s_last) state_next = ST_CHECK;
            ST_CHECK: state_next = ST_DIV;
            ST_DIV:   if (sts.div_done) state_next = ST_OUT;
            ST_OUT:   if (m_ready) state_next = ST_RUN;
            default:  state_next = ST_RUN;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_RUN: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            ST_CHECK: cmd.check = 1'b1;
            ST_DIV:   cmd.load  = sts.div_done;
            ST_OUT: begin
                m_valid   = 1'b1;
                cmd.clear = m_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_RUN;
        else          state_reg <= state_next;
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result open together");
    a_last_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("input taken after final byte");
    a_done_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV && sts.div_done |=> m_valid)
        else $error("result not presented after divide");
    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide state");
endmodule
`default_nettype wire

@@ src/wav_riff_header_parser.sv @@
// WAV RIFF header parser, top level.
// Input: s_valid/s_ready/s_data, one file byte per transfer, s_data.last on the
// final byte. Output: m_valid/m_ready/m_data, one result per file.
// Bytes are taken one per cycle while the parser runs. After the final byte
// transfer, s_ready drops: a final-check step, then a bit-serial divide (data
// size by frame size), then a result load. The result is held until m_ready;
// on that transfer the parser returns to its reset state and s_ready rises the
// next cycle.
// A failed file gives ok=0 with all other fields zero.
// Reset (aresetn low, synchronous) clears the byte parser state; no result is pending.
// While the receiver stalls, the result stays on m_data and no byte is taken.
// Depends on wrp_pkg, wrp_ctrl, wrp_dp, wrp_div.
`default_nettype none
module wav_riff_header_parser
    import wrp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);
    cmd_t cmd;
    sts_t sts;

    wrp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last),
        .m_ready (m_ready),
        .sts     (sts),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .cmd     (cmd)
    );

    wrp_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );
endmodule
`default_nettype wire
